### hdl/sfdt_pkg.sv
// ----------------------------------------------------------------------------
// sfdt_pkg
// Shared types, register indexes and helpers for the span fill block.
// ----------------------------------------------------------------------------
package sfdt_pkg;

  localparam int LANES    = 5;   // depth, R, G, B, A
  localparam int DIV_BITS = 17;

  localparam logic [2:0] REG_DTE   = 3'd0;
  localparam logic [2:0] REG_DFUNC = 3'd1;
  localparam logic [2:0] REG_DOP   = 3'd2;
  localparam logic [2:0] REG_WW    = 3'd3;
  localparam logic [2:0] REG_WH    = 3'd4;

  localparam logic [1:0] FUNC_LESS   = 2'd1;
  localparam logic [1:0] FUNC_ALWAYS = 2'd2;
  localparam logic       OP_COPY     = 1'b0;

  typedef enum logic [1:0] {
    KIND_DRAW,
    KIND_NULL,
    KIND_READ
  } kind_t;

  typedef logic signed [16:0] step_t;
  typedef logic signed [17:0] quot_t;

  typedef struct packed {
    kind_t        kind;
    logic [5:0]   row;
    logic [5:0]   col;
    logic [6:0]   len;
    logic [15:0]  sdepth;
    step_t        ddepth;
    logic [63:0]  scol;
    logic [63:0]  dcol;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  drawn;
    logic [6:0]  rejected;
    logic [31:0] color;
    logic [15:0] depth;
  } res_t;

  typedef struct packed {
    logic       dte;
    logic [1:0] dfunc;
    logic       dop;
    logic [6:0] ww;
    logic [6:0] wh;
  } cfg_t;

  // clamp to 0..256, then round-half-up of c*255/256
  function automatic logic [7:0] color_byte(input logic signed [18:0] c);
    logic [8:0]  cc;
    logic [16:0] prod;
    if (c < 0) begin
      cc = 9'd0;
    end else if (c > 19'sd256) begin
      cc = 9'd256;
    end else begin
      cc = c[8:0];
    end
    prod = {cc, 8'b0} - {8'b0, cc} + 17'd128;
    return prod[15:8];
  endfunction

endpackage

### hdl/sfdt_fifo.sv
// ----------------------------------------------------------------------------
// sfdt_fifo
// Two-entry queue of packed beats.
// ----------------------------------------------------------------------------
module sfdt_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### hdl/sfdt_front.sv
// ----------------------------------------------------------------------------
// sfdt_front
// Takes input beats, sorts them into draw, empty draw and read, and queues
// them for the back end.
// ----------------------------------------------------------------------------
module sfdt_front
  import sfdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [5:0]  row,
  input  logic [5:0]  start_col,
  input  logic [6:0]  span_length,
  input  logic [15:0] start_depth,
  input  logic [16:0] depth_step_total,
  input  logic [63:0] start_color,
  input  logic [63:0] color_step_total,
  input  logic        deq,
  output logic        head_valid,
  output cmd_t        head
);

  cmd_t item;
  logic q_empty;

  always_comb begin
    item.kind   = cmd ? KIND_READ : ((span_length == 7'd0) ? KIND_NULL : KIND_DRAW);
    item.row    = row;
    item.col    = start_col;
    item.len    = span_length;
    item.sdepth = start_depth;
    item.ddepth = depth_step_total;
    item.scol   = start_color;
    item.dcol   = color_step_total;
  end

  sfdt_fifo #(.W($bits(cmd_t))) u_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (item),
    .full  (full),
    .pop   (deq),
    .dout  (head),
    .empty (q_empty)
  );

  assign head_valid = !q_empty;

endmodule

### hdl/sfdt_div.sv
// ----------------------------------------------------------------------------
// sfdt_div
// Five-lane restoring divider, one quotient bit per cycle. Gives the floor
// quotient and the nonnegative remainder of each step total over the length.
// ----------------------------------------------------------------------------
module sfdt_div
  import sfdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [6:0] len,
  input  step_t      num  [LANES],
  output logic       done,
  output quot_t      quot [LANES],
  output logic [6:0] modv [LANES]
);

  logic        busy;
  logic [4:0]  cnt;
  logic [6:0]  dvs;
  logic [16:0] mag  [LANES];
  logic [6:0]  rem  [LANES];
  logic        neg  [LANES];
  logic [7:0]  tmp  [LANES];
  logic [7:0]  diff [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      tmp[l]  = {rem[l], mag[l][16]};
      diff[l] = tmp[l] - {1'b0, dvs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(DIV_BITS);
        dvs  <= len;
        for (int l = 0; l < LANES; l++) begin
          neg[l] <= num[l][16];
          mag[l] <= num[l][16] ? 17'(-num[l]) : 17'(num[l]);
          rem[l] <= 7'd0;
        end
      end else if (busy) begin
        if (cnt != 5'd0) begin
          cnt <= cnt - 5'd1;
          for (int l = 0; l < LANES; l++) begin
            if (tmp[l] >= {1'b0, dvs}) begin
              rem[l] <= diff[l][6:0];
              mag[l] <= {mag[l][15:0], 1'b1};
            end else begin
              rem[l] <= tmp[l][6:0];
              mag[l] <= {mag[l][15:0], 1'b0};
            end
          end
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          for (int l = 0; l < LANES; l++) begin
            if (neg[l] && rem[l] != 7'd0) begin
              quot[l] <= -$signed({1'b0, mag[l]}) - 18'sd1;
              modv[l] <= dvs - rem[l];
            end else if (neg[l]) begin
              quot[l] <= -$signed({1'b0, mag[l]});
              modv[l] <= rem[l];
            end else begin
              quot[l] <= $signed({1'b0, mag[l]});
              modv[l] <= rem[l];
            end
          end
        end
      end
    end
  end

endmodule

### hdl/sfdt_back.sv
// ----------------------------------------------------------------------------
// sfdt_back
// Executes queued commands against the depth and color stores: clears them
// after reset, walks a span one pixel at a time (S_PIX then S_PIXW), serves reads.
// ----------------------------------------------------------------------------
module sfdt_back
  import sfdt_pkg::*;
#(
  parameter int CELLS = 4096
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic head_valid,
  input  cmd_t head,
  output logic deq,
  output logic clearing,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IW = (AW + 1 > 15) ? AW + 1 : 15;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RDATA, S_DIV, S_PIX, S_PIXW, S_DONE
  } state_t;

  state_t      state;
  cmd_t        cur;
  logic [AW-1:0] clr_cnt;
  logic [12:0] base;
  logic [12:0] rd_base;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] pix_idx;
  logic [7:0]  x;
  logic [6:0]  off;
  logic        rd_ok;
  logic        pix_ok;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [6:0]  drawn;
  logic [6:0]  rejected;

  logic [15:0] dmem [CELLS];
  logic [31:0] cmem [CELLS];
  logic [15:0] dq;
  logic [31:0] cq;
  logic        dwe;
  logic        cwe;
  logic [15:0] dwdata;
  logic [31:0] cwdata;

  logic        div_start;
  logic        div_done;
  step_t       div_num  [LANES];
  quot_t       div_quot [LANES];
  logic [6:0]  div_mod  [LANES];
  quot_t       qstep [LANES];
  logic [6:0]  rstep [LANES];
  quot_t       qacc  [LANES];
  logic [6:0]  racc  [LANES];
  logic [7:0]  rsum  [LANES];

  logic signed [18:0] z;
  logic [15:0] zsat;
  logic        pass;
  logic        take;
  logic [31:0] word;

  assign clearing = (state == S_CLEAR);
  assign take     = (state == S_IDLE) && head_valid && !res_full;
  assign deq      = take;
  assign div_start = take && (head.kind == KIND_DRAW);

  always_comb begin
    div_num[0] = head.ddepth;
    for (int k = 0; k < 4; k++) begin
      div_num[k+1] = $signed({head.dcol[63-16*k], head.dcol[63-16*k -: 16]});
    end
  end

  sfdt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .len   (head.len),
    .num   (div_num),
    .done  (div_done),
    .quot  (div_quot),
    .modv  (div_mod)
  );

  assign rd_base = {7'd0, head.row} * {6'd0, cfg.ww};
  assign rd_idx  = IW'(rd_base) + IW'(head.col);
  assign x       = {2'b0, cur.col} + {1'b0, off};
  assign pix_idx = IW'(base) + IW'(x);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rsum[l] = {1'b0, racc[l]} + {1'b0, rstep[l]};
    end
    z = $signed({3'b0, cur.sdepth}) + {qacc[0][17], qacc[0]};
    if (z < 0) begin
      zsat = 16'd0;
    end else if (z > 19'sd65535) begin
      zsat = 16'hFFFF;
    end else begin
      zsat = z[15:0];
    end
    if (cfg.dfunc == FUNC_LESS) begin
      pass = zsat < dq;
    end else begin
      pass = (cfg.dfunc == FUNC_ALWAYS);
    end
    for (int k = 0; k < 4; k++) begin
      word[31-8*k -: 8] = color_byte(
        $signed({{3{cur.scol[63-16*k]}}, cur.scol[63-16*k -: 16]})
        + {qacc[k+1][17], qacc[k+1]});
    end
  end

  assign raddr  = (state == S_IDLE) ? rd_idx[AW-1:0] : pix_idx[AW-1:0];
  assign waddr  = clearing ? clr_cnt : pix_addr;
  assign dwe    = clearing || ((state == S_PIXW) && pix_ok && cfg.dte && pass);
  assign cwe    = clearing ||
                  ((state == S_PIXW) && pix_ok && (!cfg.dte || pass) && cfg.dop == OP_COPY);
  assign dwdata = clearing ? 16'hFFFF : zsat;
  assign cwdata = clearing ? 32'd0 : word;

  always_ff @(posedge clk) begin
    if (dwe) begin
      dmem[waddr] <= dwdata;
    end
    if (cwe) begin
      cmem[waddr] <= cwdata;
    end
    dq <= dmem[raddr];
    cq <= cmem[raddr];
  end

  assign res_push = (state == S_DONE) || (state == S_RDATA);

  always_comb begin
    res = '0;
    if (state == S_RDATA) begin
      res.color = rd_ok ? cq : 32'd0;
      res.depth = rd_ok ? dq : 16'd0;
    end else begin
      res.drawn    = drawn;
      res.rejected = rejected;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            cur      <= head;
            base     <= rd_base;
            drawn    <= 7'd0;
            rejected <= 7'd0;
            rd_ok    <= ({1'b0, head.col} < cfg.ww) && ({1'b0, head.row} < cfg.wh) &&
                        (rd_idx < IW'(CELLS));
            unique case (head.kind)
              KIND_READ: state <= S_RDATA;
              KIND_NULL: state <= S_DONE;
              default:   state <= S_DIV;
            endcase
          end
        end
        S_RDATA: state <= S_IDLE;
        S_DIV: begin
          if (div_done) begin
            for (int l = 0; l < LANES; l++) begin
              qstep[l] <= div_quot[l];
              rstep[l] <= div_mod[l];
              qacc[l]  <= '0;
              racc[l]  <= 7'd0;
            end
            off   <= 7'd0;
            state <= S_PIX;
          end
        end
        S_PIX: begin
          pix_addr <= pix_idx[AW-1:0];
          pix_ok   <= (x < {1'b0, cfg.ww}) && ({1'b0, cur.row} < cfg.wh) &&
                      (pix_idx < IW'(CELLS));
          state    <= S_PIXW;
        end
        S_PIXW: begin
          if (!pix_ok || (cfg.dte && !pass)) begin
            rejected <= rejected + 7'd1;
          end else begin
            drawn <= drawn + 7'd1;
          end
          for (int l = 0; l < LANES; l++) begin
            if (rsum[l] >= {1'b0, cur.len}) begin
              racc[l] <= 7'(rsum[l] - {1'b0, cur.len});
              qacc[l] <= qacc[l] + qstep[l] + 18'sd1;
            end else begin
              racc[l] <= rsum[l][6:0];
              qacc[l] <= qacc[l] + qstep[l];
            end
          end
          off <= off + 7'd1;
          state <= (off == cur.len - 7'd1) ? S_DONE : S_PIX;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/span_fill_depth_test.sv
// ----------------------------------------------------------------------------
// span_fill_depth_test
// Span fill with depth test into on-chip depth and color stores.
// ----------------------------------------------------------------------------
// Input channel: push/full. A beat is a draw (cmd 0) or a read (cmd 1).
// Result channel: empty/pop, one beat per input beat, in order. A draw
// returns drawn/rejected counts, a read returns stored color and depth.
// Config: APB registers at 4*i. The user must write them only while the
// block is idle; the block itself does not enforce it. After reset the
// stores are swept, all FB_WIDTH*FB_HEIGHT cells (4096 at default), and
// full stays high until the sweep ends.
// A read is taken in the idle state and its result pushed from S_RDATA;
// an empty draw goes straight to S_DONE. A draw first runs the shared
// five-lane divider that sets up the interpolation steps, then does a
// store read-modify-write per pixel (S_PIX, S_PIXW) before S_DONE.
// The back end runs one command at a time; a two-beat input queue and a
// two-beat result queue decouple it from both sides. When the receiver
// stalls, the back end halts before taking a command with no result slot.
// ----------------------------------------------------------------------------
module span_fill_depth_test
  import sfdt_pkg::*;
#(
  parameter int FB_WIDTH  = 64,
  parameter int FB_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [5:0]  row,
  input  logic [5:0]  start_col,
  input  logic [6:0]  span_length,
  input  logic [15:0] start_depth,
  input  logic [16:0] depth_step_total,
  input  logic [63:0] start_color,
  input  logic [63:0] color_step_total,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  drawn_count,
  output logic [6:0]  rejected_count,
  output logic [31:0] pixel_color,
  output logic [15:0] pixel_depth,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = FB_WIDTH * FB_HEIGHT;

  cfg_t cfg;
  logic q_full;
  logic clearing;
  logic head_valid;
  cmd_t head;
  logic deq;
  logic res_full;
  logic res_push;
  res_t res_in;
  res_t res_out;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dte   <= 1'b0;
      cfg.dfunc <= FUNC_LESS;
      cfg.dop   <= OP_COPY;
      cfg.ww    <= 7'd64;
      cfg.wh    <= 7'd64;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_DTE:   cfg.dte   <= pwdata[0];
        REG_DFUNC: cfg.dfunc <= pwdata[1:0];
        REG_DOP:   cfg.dop   <= pwdata[0];
        REG_WW:    cfg.ww    <= pwdata[6:0];
        REG_WH:    cfg.wh    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DTE:   prdata = {31'd0, cfg.dte};
      REG_DFUNC: prdata = {30'd0, cfg.dfunc};
      REG_DOP:   prdata = {31'd0, cfg.dop};
      REG_WW:    prdata = {25'd0, cfg.ww};
      REG_WH:    prdata = {25'd0, cfg.wh};
      default:   prdata = 32'd0;
    endcase
  end

  assign full = q_full || clearing;

  sfdt_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push && !clearing),
    .full             (q_full),
    .cmd              (cmd),
    .row              (row),
    .start_col        (start_col),
    .span_length      (span_length),
    .start_depth      (start_depth),
    .depth_step_total (depth_step_total),
    .start_color      (start_color),
    .color_step_total (color_step_total),
    .deq              (deq),
    .head_valid       (head_valid),
    .head             (head)
  );

  sfdt_back #(.CELLS(CELLS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .deq        (deq),
    .clearing   (clearing),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  sfdt_fifo #(.W($bits(res_t))) u_res (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign drawn_count    = res_out.drawn;
  assign rejected_count = res_out.rejected;
  assign pixel_color    = res_out.color;
  assign pixel_depth    = res_out.depth;

endmodule

### dv/tb_span_fill_depth_test.sv
// ----------------------------------------------------------------------------
// tb_span_fill_depth_test
// Drives draw and read beats into the span fill block under a series of
// register settings and checks every result beat against a software copy
// of the depth and color stores or, for some directed beats, a fixed value.
// ----------------------------------------------------------------------------
module tb_span_fill_depth_test
  import sfdt_pkg::*;
();

  localparam int CELLS      = 64 * 64;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic        cmd;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [6:0]  len;
    logic [15:0] sdepth;
    logic [16:0] dstep;
    logic [63:0] scol;
    logic [63:0] dcol;
  } span_t;

  typedef struct {
    span_t s;
    bit    typed;
    res_t  want;
  } dir_row_t;

  typedef struct {
    logic       dte;
    logic [1:0] dfunc;
    logic       dop;
    logic [6:0] ww;
    logic [6:0] wh;
  } setting_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        cmd = 1'b0;
  logic [5:0]  row = '0;
  logic [5:0]  start_col = '0;
  logic [6:0]  span_length = '0;
  logic [15:0] start_depth = '0;
  logic [16:0] depth_step_total = '0;
  logic [63:0] start_color = '0;
  logic [63:0] color_step_total = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [6:0]  drawn_count;
  logic [6:0]  rejected_count;
  logic [31:0] pixel_color;
  logic [15:0] pixel_depth;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  span_fill_depth_test dut (.*);

  always #5 clk = ~clk;

  // shadow stores and registers
  logic [15:0] depth_mem [CELLS];
  logic [31:0] color_mem [CELLS];
  setting_t    cfg;

  res_t        pixel_res_q [$];
  int          err_cnt = 0;
  int          long_stall = 0;
  int          burst_left = 0;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic bit pix_index(input longint x, input longint y, output int unsigned idx);
    longint i;
    if (x >= cfg.ww || y >= cfg.wh) return 0;
    i = y * cfg.ww + x;
    if (i >= CELLS) return 0;
    idx = 32'(i);
    return 1;
  endfunction

  function automatic longint chan(input logic [63:0] v, input int k);
    logic [15:0] c;
    c = v[63 - 16 * k -: 16];
    return longint'($signed(c));
  endfunction

  function automatic res_t predict_span(input span_t s);
    res_t        r;
    int unsigned idx;
    longint      len, dd, z, c;
    int unsigned drawn, rej;
    logic        pass;
    logic [31:0] word;
    r = '0;
    drawn = 0;
    rej = 0;
    if (s.cmd) begin
      if (pix_index(s.col, s.row, idx)) begin
        r.color = color_mem[idx];
        r.depth = depth_mem[idx];
      end
      return r;
    end
    len = s.len;
    dd = longint'($signed(s.dstep));
    for (longint off = 0; off < len; off++) begin
      if (!pix_index(longint'(s.col) + off, s.row, idx)) begin
        rej++;
        continue;
      end
      z = longint'(s.sdepth) + floor_div(off * dd, len);
      if (z < 0) z = 0;
      if (z > 65535) z = 65535;
      if (cfg.dte) begin
        if (cfg.dfunc == FUNC_LESS) pass = z < depth_mem[idx];
        else pass = (cfg.dfunc == FUNC_ALWAYS);
        if (!pass) begin
          rej++;
          continue;
        end
        depth_mem[idx] = z[15:0];
      end
      if (cfg.dop == OP_COPY) begin
        word = '0;
        for (int k = 0; k < 4; k++) begin
          c = chan(s.scol, k) + floor_div(off * chan(s.dcol, k), len);
          if (c < 0) c = 0;
          if (c > 256) c = 256;
          c = (c * 255 + 128) >>> 8;
          word[31 - 8 * k -: 8] = c[7:0];
        end
        color_mem[idx] = word;
      end
      drawn++;
    end
    r.drawn = drawn[6:0];
    r.rejected = rej[6:0];
    return r;
  endfunction

  function automatic logic [63:0] rand_chans();
    logic [63:0] v;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 1)) v[63 - 16 * k -: 16] = 16'($urandom_range(0, 600)) - 16'd150;
      else v[63 - 16 * k -: 16] = 16'($urandom);
    end
    return v;
  endfunction

  function automatic span_t rand_span();
    span_t s;
    int    pick;
    s.cmd = ($urandom_range(0, 3) == 0);
    s.row = 6'($urandom);
    s.col = 6'($urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0) s.len = 7'd0;
    else if (pick == 1) s.len = 7'd64;
    else if (pick == 2) s.len = 7'($urandom_range(65, 127));
    else s.len = 7'($urandom_range(1, 16));
    s.sdepth = 16'($urandom);
    s.dstep = 17'($urandom);
    s.scol = rand_chans();
    s.dcol = rand_chans();
    return s;
  endfunction

  // one input beat; bursts of random length separated by random gaps
  task automatic send_span(input span_t s, input bit typed, input res_t want);
    res_t got;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    push <= 1'b1;
    cmd <= s.cmd;
    row <= s.row;
    start_col <= s.col;
    span_length <= s.len;
    start_depth <= s.sdepth;
    depth_step_total <= s.dstep;
    start_color <= s.scol;
    color_step_total <= s.dcol;
    do @(posedge clk); while (full);
    got = predict_span(s);
    pixel_res_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pixel_res_q.size() != 0);
  endtask

  // setup then access; the caller releases the bus after the last write
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t st);
    apb_write(REG_DTE, {31'd0, st.dte});
    apb_write(REG_DFUNC, {30'd0, st.dfunc});
    apb_write(REG_DOP, {31'd0, st.dop});
    apb_write(REG_WW, {25'd0, st.ww});
    apb_write(REG_WH, {25'd0, st.wh});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg = st;
  endtask

  // result side: compare on accept, then pick next pop
  int pop_pct = 100;
  int pop_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pixel_res_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          res_t w;
          w = pixel_res_q.pop_front();
          if (drawn_count !== w.drawn)
            report($sformatf("drawn_count %0d want %0d", drawn_count, w.drawn));
          if (rejected_count !== w.rejected)
            report($sformatf("rejected_count %0d want %0d", rejected_count, w.rejected));
          if (pixel_color !== w.color)
            report($sformatf("pixel_color %h want %h", pixel_color, w.color));
          if (pixel_depth !== w.depth)
            report($sformatf("pixel_depth %h want %h", pixel_depth, w.depth));
        end
      end
      pop_phase++;
      if (pop_phase % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: pop_pct = 100;
          1: pop_pct = 70;
          default: pop_pct = 25;
        endcase
      end
      if (long_stall > 0) begin
        long_stall--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) < pop_pct);
      end
    end
  end

  int idle_cyc = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  dir_row_t dir_tbl [15];
  setting_t phases [12];

  initial begin
    span_t s;
    res_t  none;
    none = '0;
    for (int i = 0; i < CELLS; i++) begin
      depth_mem[i] = 16'hFFFF;
      color_mem[i] = '0;
    end
    cfg = '{1'b0, 2'd1, 1'b0, 7'd64, 7'd64};

    dir_tbl[0]  = '{'{1, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 32'h0, 16'hFFFF}};
    dir_tbl[1]  = '{'{1, 63, 63, 0, 0, 0, 0, 0}, 1, '{0, 0, 32'h0, 16'hFFFF}};
    dir_tbl[2]  = '{'{0, 3, 3, 0, 16'h1234, 17'h1FFFF, '1, '1}, 1, '{0, 0, 0, 0}};
    dir_tbl[3]  = '{'{0, 0, 0, 64, 0, 0, 64'h0100_0100_0100_0100, 0}, 1, '{64, 0, 0, 0}};
    dir_tbl[4]  = '{'{1, 0, 5, 0, 0, 0, 0, 0}, 1, '{0, 0, 32'hFFFF_FFFF, 16'hFFFF}};
    dir_tbl[5]  = '{'{0, 1, 63, 64, 0, 0, 0, 0}, 1, '{1, 63, 0, 0}};
    dir_tbl[6]  = '{'{0, 20, 10, 64, 0, 0, 0, 0}, 1, '{54, 10, 0, 0}};
    dir_tbl[7]  = '{'{0, 20, 10, 40, 16'h8000, 17'h0FFFF, 64'h8000_FFFF_0000_7FFF,
                     64'h7FFF_0180_FE00_8000}, 0, none};
    dir_tbl[8]  = '{'{1, 20, 30, 0, 0, 0, 0, 0}, 0, none};
    dir_tbl[9]  = '{'{0, 30, 0, 16, 16'h0000, 17'h10001, 64'h0100_0080_0000_00FF,
                     64'h8000_8000_8000_8000}, 0, none};
    dir_tbl[10] = '{'{0, 31, 0, 16, 16'hFFFF, 17'h0FFFF, 64'h0000_0000_0000_0000,
                     64'h7FFF_7FFF_7FFF_7FFF}, 0, none};
    dir_tbl[11] = '{'{0, 63, 0, 1, 16'h0, 17'h0, 64'h0080_0040_0020_0010, 0}, 0, none};
    dir_tbl[12] = '{'{1, 63, 0, 0, 0, 0, 0, 0}, 0, none};
    dir_tbl[13] = '{'{0, 40, 0, 127, 0, 0, 0, 0}, 1, '{64, 63, 0, 0}};
    dir_tbl[14] = '{'{1, 31, 7, 0, 0, 0, 0, 0}, 0, none};

    phases[0]  = '{1, 1, 0, 64, 64};
    phases[1]  = '{1, 0, 0, 64, 64};
    phases[2]  = '{1, 2, 1, 64, 64};
    phases[3]  = '{1, 3, 0, 64, 64};
    phases[4]  = '{0, 1, 1, 1, 1};
    phases[5]  = '{1, 1, 0, 37, 50};
    phases[6]  = '{1, 1, 0, 64, 1};
    phases[7]  = '{0, 2, 0, 1, 64};
    phases[8]  = '{1, 1, 0, 100, 64};
    phases[9]  = '{1, 1, 0, 0, 64};
    phases[10] = '{1, 2, 0, 64, 64};
    phases[11] = '{1, 1, 0, 127, 127};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[i]) send_span(dir_tbl[i].s, dir_tbl[i].typed, dir_tbl[i].want);
    drain();

    foreach (phases[p]) begin
      apply_setting(phases[p]);
      if (p == 0) long_stall = 3000;
      for (int n = 0; n < 153; n++) begin
        s = rand_span();
        send_span(s, 0, none);
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (pixel_res_q.size() != 0) report("expected results left over");
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/sfdt_pkg.sv
hdl/sfdt_fifo.sv
hdl/sfdt_front.sv
hdl/sfdt_div.sv
hdl/sfdt_back.sv
hdl/span_fill_depth_test.sv
dv/tb_span_fill_depth_test.sv
